### src/link_egress_watchdog_core_defines.svh
// Assertion macros used by the watchdog top level.
`ifndef LINK_EGRESS_WATCHDOG_CORE_DEFINES_SVH
`define LINK_EGRESS_WATCHDOG_CORE_DEFINES_SVH
`ifndef SYNTH
// Clocked check, disabled while reset is asserted
`define LEW_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked check that also holds during reset
`define LEW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LEW_ASSERT(lbl, clk, rstn, prop, msg)
`define LEW_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### src/lew_pkg.sv
// Types and constants for the link egress watchdog.
`timescale 1ns / 1ps
package lew_pkg;

	// Item kinds
	localparam logic [1:0] FUNC_TICK       = 2'd0;
	localparam logic [1:0] FUNC_CONNECT    = 2'd1;
	localparam logic [1:0] FUNC_DISCONNECT = 2'd2;

	// Probe outcomes (anything else counts as dead)
	localparam logic [1:0] PROBE_ALIVE = 2'd0;
	localparam logic [1:0] PROBE_BUSY  = 2'd1;

	// Register map, by word index
	localparam int          REG_IDX_W          = 3;
	localparam int          PADDR_W            = 5;
	localparam logic [2:0] REG_PROBE_PERIOD   = 3'd0;
	localparam logic [2:0] REG_DEAD_AFTER     = 3'd1;
	localparam logic [2:0] REG_REBOOT_AFTER   = 3'd2;
	localparam logic [2:0] REG_GRACE_MAX      = 3'd3;
	localparam logic [2:0] REG_MIN_UPTIME     = 3'd4;
	localparam logic [2:0] REG_MIN_STANDBY    = 3'd5;

	typedef struct packed {
		logic [31:0] probe_period_ms;
		logic [31:0] dead_after_ms;
		logic [31:0] reboot_after_ms;
		logic [31:0] busy_grace_max_ms;
		logic [31:0] min_uptime_ms;
		logic [31:0] min_standby_ms;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		probe_period_ms:   32'd5000,
		dead_after_ms:     32'd60000,
		reboot_after_ms:   32'd300000,
		busy_grace_max_ms: 32'd60000,
		min_uptime_ms:     32'd900000,
		min_standby_ms:    32'd300000
	};

	typedef struct packed {
		logic        probe_taken;
		logic        reconnect_request;
		logic        reboot_request;
		logic        reboot_deferred;
		logic        escalation_stage;
		logic [31:0] dead_for_ms;
	} res_t;

endpackage

### src/lew_step.sv
// Next-state and result logic for one watchdog item.
`timescale 1ns / 1ps
module lew_step #(
	parameter int TIME_BITS = 32
) (
	input  lew_pkg::cfg_t         cfg,
	input  logic [1:0]            func,
	input  logic [TIME_BITS-1:0]  now_ms,
	input  logic                  link_up,
	input  logic                  station_mode,
	input  logic                  machine_standby,
	input  logic [1:0]            probe_outcome,
	input  logic                  socket_ready,
	input  logic [TIME_BITS-1:0]  last_alive,
	input  logic [TIME_BITS-1:0]  last_probe,
	input  logic [TIME_BITS-1:0]  standby_start,
	input  logic                  stage,
	input  logic [31:0]           grace,
	input  logic                  held,
	output logic                  nxt_socket_ready,
	output logic [TIME_BITS-1:0]  nxt_last_alive,
	output logic [TIME_BITS-1:0]  nxt_last_probe,
	output logic [TIME_BITS-1:0]  nxt_standby_start,
	output logic                  nxt_stage,
	output logic [31:0]           nxt_grace,
	output logic                  nxt_held,
	output lew_pkg::res_t         res
);

	// Common compare width of timestamps and 32-bit registers
	localparam int CW = (TIME_BITS > 32) ? TIME_BITS : 32;

	logic [TIME_BITS-1:0] probe_gap;
	logic                 probe_due;
	logic [31:0]          headroom;
	logic [31:0]          grace_busy;
	logic [TIME_BITS-1:0] standby_tick;
	logic [TIME_BITS-1:0] standby_gap;
	logic                 reboot_ok;

	// Probe due check and saturating busy grace
	always_comb begin
		probe_gap = now_ms - last_probe;
		probe_due = CW'(probe_gap) >= CW'(cfg.probe_period_ms);
		headroom  = cfg.busy_grace_max_ms - grace;
		if (grace >= cfg.busy_grace_max_ms) begin
			grace_busy = grace;
		end else if (cfg.probe_period_ms >= headroom) begin
			grace_busy = cfg.busy_grace_max_ms;
		end else begin
			grace_busy = grace + cfg.probe_period_ms;
		end
	end

	// Standby tracking on ticks; zero marks not in standby
	always_comb begin
		if (!machine_standby) begin
			standby_tick = '0;
		end else if (standby_start == '0) begin
			standby_tick = now_ms;
		end else begin
			standby_tick = standby_start;
		end
		standby_gap = now_ms - standby_tick;
		reboot_ok   = (CW'(now_ms) >= CW'(cfg.min_uptime_ms)) && (standby_tick != '0)
			&& (CW'(standby_gap) >= CW'(cfg.min_standby_ms));
	end

	// Main step
	always_comb begin
		logic [TIME_BITS-1:0] alive_eff;
		logic [31:0]          grace_eff;
		logic                 stage_eff;
		logic                 held_eff;
		logic [TIME_BITS-1:0] since;
		logic [CW-1:0]        dead_c;

		nxt_socket_ready  = socket_ready;
		nxt_last_alive    = last_alive;
		nxt_last_probe    = last_probe;
		nxt_standby_start = standby_start;
		nxt_stage         = stage;
		nxt_grace         = grace;
		nxt_held          = held;
		res               = '0;

		alive_eff = last_alive;
		grace_eff = grace;
		stage_eff = stage;
		held_eff  = held;
		since     = '0;
		dead_c    = '0;

		case (func)
			lew_pkg::FUNC_CONNECT: begin
				nxt_socket_ready = 1'b1;
				nxt_last_alive   = now_ms;
				nxt_last_probe   = now_ms;
				nxt_stage        = 1'b0;
				nxt_grace        = '0;
			end
			lew_pkg::FUNC_DISCONNECT: begin
				nxt_socket_ready = 1'b0;
			end
			lew_pkg::FUNC_TICK: begin
				nxt_standby_start = standby_tick;
				if (!socket_ready || !link_up) begin
					nxt_last_alive = now_ms;
					nxt_stage      = 1'b0;
					nxt_grace      = '0;
					nxt_held       = 1'b0;
				end else begin
					// apply the probe outcome first
					if (probe_due) begin
						nxt_last_probe  = now_ms;
						res.probe_taken = 1'b1;
						if (probe_outcome == lew_pkg::PROBE_ALIVE) begin
							alive_eff = now_ms;
							grace_eff = '0;
							stage_eff = 1'b0;
							held_eff  = 1'b0;
						end else if (probe_outcome == lew_pkg::PROBE_BUSY) begin
							grace_eff = grace_busy;
						end
					end
					since  = now_ms - alive_eff;
					dead_c = (CW'(since) > CW'(grace_eff)) ? CW'(since) - CW'(grace_eff) : '0;

					// escalation
					if (dead_c >= CW'(cfg.dead_after_ms)) begin
						if (!stage_eff) begin
							stage_eff             = 1'b1;
							res.reconnect_request = station_mode;
						end else if (dead_c >= CW'(cfg.reboot_after_ms)) begin
							if (reboot_ok) begin
								res.reboot_request = 1'b1;
							end else if (!held_eff) begin
								held_eff            = 1'b1;
								res.reboot_deferred = 1'b1;
							end
						end
					end
					nxt_last_alive = alive_eff;
					nxt_grace      = grace_eff;
					nxt_stage      = stage_eff;
					nxt_held       = held_eff;
				end
			end
			default: begin
			end
		endcase

		res.escalation_stage = nxt_stage;
		res.dead_for_ms      = dead_c[31:0];
	end

endmodule

### src/link_egress_watchdog_core.sv
// Top level of the link egress watchdog: register file, item pipeline, assertions.
//
//  Channel  Signals                                         Transfer when
//  -------  ----------------------------------------------  --------------------------------
//  in       in_valid/in_ready, func .. probe_outcome        in_valid & in_ready
//  out      out_valid/out_ready, probe_taken .. dead_for_ms  out_valid & out_ready
//  cfg      psel/penable/pwrite/paddr/pwdata/prdata/pready  psel & penable & pwrite (pready=1)
//
// One item per cycle while out_ready is high. An item is held in an input stage,
// its step is evaluated combinationally by lew_step and written to the result register.
// Reset clears all watchdog state and loads the register defaults; there is no clearing pass.
// When out_ready is low the result register holds, the input stage fills, then in_ready drops.
`timescale 1ns / 1ps
`include "link_egress_watchdog_core_defines.svh"
module link_egress_watchdog_core #(
	parameter int TIME_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lew_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// input items
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  func,
	input  logic [31:0]                 now_ms,
	input  logic                        link_up,
	input  logic                        station_mode,
	input  logic                        machine_standby,
	input  logic [1:0]                  probe_outcome,
	// results
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        probe_taken,
	output logic                        reconnect_request,
	output logic                        reboot_request,
	output logic                        reboot_deferred,
	output logic                        escalation_stage,
	output logic [31:0]                 dead_for_ms
);

	lew_pkg::cfg_t cfg_q;
	logic [lew_pkg::REG_IDX_W-1:0] reg_idx;

	// input stage
	logic                 v_s1;
	logic [1:0]           func_s1;
	logic [TIME_BITS-1:0] now_s1;
	logic                 link_up_s1;
	logic                 station_s1;
	logic                 standby_s1;
	logic [1:0]           outcome_s1;

	// watchdog state
	logic                 socket_ready_q;
	logic [TIME_BITS-1:0] last_alive_q;
	logic [TIME_BITS-1:0] last_probe_q;
	logic [TIME_BITS-1:0] standby_start_q;
	logic                 stage_q;
	logic [31:0]          grace_q;
	logic                 held_q;

	logic                 nxt_socket_ready;
	logic [TIME_BITS-1:0] nxt_last_alive;
	logic [TIME_BITS-1:0] nxt_last_probe;
	logic [TIME_BITS-1:0] nxt_standby_start;
	logic                 nxt_stage;
	logic [31:0]          nxt_grace;
	logic                 nxt_held;
	lew_pkg::res_t        res;

	// result register
	logic                 out_v_q;
	lew_pkg::res_t        res_q;

	logic                 advance;
	logic                 step_en;

	// Register file
	assign pready  = 1'b1;
	assign reg_idx = paddr[lew_pkg::PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= lew_pkg::CFG_RESET;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				lew_pkg::REG_PROBE_PERIOD: cfg_q.probe_period_ms   <= pwdata;
				lew_pkg::REG_DEAD_AFTER:   cfg_q.dead_after_ms     <= pwdata;
				lew_pkg::REG_REBOOT_AFTER: cfg_q.reboot_after_ms   <= pwdata;
				lew_pkg::REG_GRACE_MAX:    cfg_q.busy_grace_max_ms <= pwdata;
				lew_pkg::REG_MIN_UPTIME:   cfg_q.min_uptime_ms     <= pwdata;
				lew_pkg::REG_MIN_STANDBY:  cfg_q.min_standby_ms    <= pwdata;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			lew_pkg::REG_PROBE_PERIOD: prdata = cfg_q.probe_period_ms;
			lew_pkg::REG_DEAD_AFTER:   prdata = cfg_q.dead_after_ms;
			lew_pkg::REG_REBOOT_AFTER: prdata = cfg_q.reboot_after_ms;
			lew_pkg::REG_GRACE_MAX:    prdata = cfg_q.busy_grace_max_ms;
			lew_pkg::REG_MIN_UPTIME:   prdata = cfg_q.min_uptime_ms;
			lew_pkg::REG_MIN_STANDBY:  prdata = cfg_q.min_standby_ms;
			default:                   prdata = '0;
		endcase
	end

	// Flow control: the step runs when the result register is free or being drained
	assign advance  = !out_v_q || out_ready;
	assign step_en  = v_s1 && advance;
	assign in_ready = !v_s1 || advance;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			func_s1    <= func;
			now_s1     <= TIME_BITS'(now_ms);
			link_up_s1 <= link_up;
			station_s1 <= station_mode;
			standby_s1 <= machine_standby;
			outcome_s1 <= probe_outcome;
		end
	end

	lew_step #(
		.TIME_BITS(TIME_BITS)
	) u_step (
		.cfg               (cfg_q),
		.func              (func_s1),
		.now_ms            (now_s1),
		.link_up           (link_up_s1),
		.station_mode      (station_s1),
		.machine_standby   (standby_s1),
		.probe_outcome     (outcome_s1),
		.socket_ready      (socket_ready_q),
		.last_alive        (last_alive_q),
		.last_probe        (last_probe_q),
		.standby_start     (standby_start_q),
		.stage             (stage_q),
		.grace             (grace_q),
		.held              (held_q),
		.nxt_socket_ready  (nxt_socket_ready),
		.nxt_last_alive    (nxt_last_alive),
		.nxt_last_probe    (nxt_last_probe),
		.nxt_standby_start (nxt_standby_start),
		.nxt_stage         (nxt_stage),
		.nxt_grace         (nxt_grace),
		.nxt_held          (nxt_held),
		.res               (res)
	);

	// Watchdog state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			socket_ready_q  <= 1'b0;
			last_alive_q    <= '0;
			last_probe_q    <= '0;
			standby_start_q <= '0;
			stage_q         <= 1'b0;
			grace_q         <= '0;
			held_q          <= 1'b0;
		end else if (step_en) begin
			socket_ready_q  <= nxt_socket_ready;
			last_alive_q    <= nxt_last_alive;
			last_probe_q    <= nxt_last_probe;
			standby_start_q <= nxt_standby_start;
			stage_q         <= nxt_stage;
			grace_q         <= nxt_grace;
			held_q          <= nxt_held;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (advance) begin
			out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			res_q <= res;
		end
	end

	assign out_valid         = out_v_q;
	assign probe_taken       = res_q.probe_taken;
	assign reconnect_request = res_q.reconnect_request;
	assign reboot_request    = res_q.reboot_request;
	assign reboot_deferred   = res_q.reboot_deferred;
	assign escalation_stage  = res_q.escalation_stage;
	assign dead_for_ms       = res_q.dead_for_ms;

	// Checks
	`LEW_ASSERT(a_in_lands, clk, arst_n, (in_valid && in_ready) |=> v_s1, "accepted item not in input stage")
	`LEW_ASSERT(a_reboot_stage, clk, arst_n, (out_valid && reboot_request) |-> escalation_stage, "reboot without stage")
	`LEW_ASSERT(a_one_action, clk, arst_n, out_valid |-> !(reconnect_request && (reboot_request || reboot_deferred)), "reconnect with reboot action")
	`LEW_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |=> (!out_valid && !v_s1), "pipeline busy in reset")

endmodule

### bench/link_egress_watchdog_core_tb.sv
// Self-checking testbench for the link egress watchdog core: directed rows, then random traffic.
`timescale 1ns / 1ps
module link_egress_watchdog_core_tb;

	// codes the package leaves unnamed
	localparam logic [1:0] FUNC_UNUSED   = 2'd3;
	localparam logic [1:0] PROBE_DEAD    = 2'd2;
	localparam logic [1:0] PROBE_UNUSED  = 2'd3;
	localparam int         STALL_MAX     = 19;
	localparam int         HOLD_CYCLES   = 200;
	localparam int         PHASE_ITEMS   = 285;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] now;
		logic        link_up;
		logic        station;
		logic        standby;
		logic [1:0]  outcome;
	} item_t;

	typedef struct packed {
		item_t         it;
		logic          lit;
		lew_pkg::res_t want;
	} row_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        psel = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite = 1'b0;
	logic [lew_pkg::PADDR_W-1:0] paddr = '0;
	logic [31:0]                 pwdata = '0;
	logic [31:0]                 prdata;
	logic                        pready;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic [1:0]                  func = lew_pkg::FUNC_TICK;
	logic [31:0]                 now_ms = '0;
	logic                        link_up = 1'b0;
	logic                        station_mode = 1'b0;
	logic                        machine_standby = 1'b0;
	logic [1:0]                  probe_outcome = lew_pkg::PROBE_ALIVE;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic                        probe_taken;
	logic                        reconnect_request;
	logic                        reboot_request;
	logic                        reboot_deferred;
	logic                        escalation_stage;
	logic [31:0]                 dead_for_ms;

	// shadow of the watchdog registers and state
	lew_pkg::cfg_t wd_cfg = lew_pkg::CFG_RESET;
	logic          wd_armed = 1'b0;
	logic [31:0]   wd_alive_at = '0;
	logic [31:0]   wd_probe_at = '0;
	logic [31:0]   wd_standby_at = '0;
	logic          wd_stage = 1'b0;
	logic [31:0]   wd_grace = '0;
	logic          wd_held = 1'b0;

	lew_pkg::res_t verdict_q[$];
	row_t  stim_rows[$];
	int    fault_count = 0;
	int    results_seen = 0;
	bit    no_idle = 1'b0;
	int    hold_asks = 0;
	int    hold_seen = 0;
	int    rx_hold = 0;
	int    rx_wait = 0;
	logic [31:0] clock_ms = '0;

	link_egress_watchdog_core DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .now_ms(now_ms), .link_up(link_up), .station_mode(station_mode),
		.machine_standby(machine_standby), .probe_outcome(probe_outcome),
		.out_valid(out_valid), .out_ready(out_ready),
		.probe_taken(probe_taken), .reconnect_request(reconnect_request),
		.reboot_request(reboot_request), .reboot_deferred(reboot_deferred),
		.escalation_stage(escalation_stage), .dead_for_ms(dead_for_ms)
	);

	always #4 clk = ~clk;

	task automatic report(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		fault_count++;
	endtask

	// One watchdog step on the shadow state; returns the result it should produce
	function automatic lew_pkg::res_t watchdog_step(input item_t it);
		lew_pkg::res_t r;
		logic [31:0]   gap;
		logic [31:0]   since;
		logic [31:0]   in_standby;
		r = '0;
		case (it.func)
			lew_pkg::FUNC_CONNECT: begin
				wd_armed = 1'b1;
				wd_alive_at = it.now;
				wd_probe_at = it.now;
				wd_stage = 1'b0;
				wd_grace = '0;
			end
			lew_pkg::FUNC_DISCONNECT: wd_armed = 1'b0;
			lew_pkg::FUNC_TICK: begin
				// zero marks "not in standby", even if standby began at time zero
				if (it.standby) begin
					if (wd_standby_at == '0)
						wd_standby_at = it.now;
				end else begin
					wd_standby_at = '0;
				end
				if (!wd_armed || !it.link_up) begin
					wd_alive_at = it.now;
					wd_stage = 1'b0;
					wd_grace = '0;
					wd_held = 1'b0;
				end else begin
					gap = it.now - wd_probe_at;
					if (gap >= wd_cfg.probe_period_ms) begin
						wd_probe_at = it.now;
						r.probe_taken = 1'b1;
						if (it.outcome == lew_pkg::PROBE_ALIVE) begin
							wd_alive_at = it.now;
							wd_stage = 1'b0;
							wd_grace = '0;
							wd_held = 1'b0;
						end else if (it.outcome == lew_pkg::PROBE_BUSY) begin
							// grace grows by one period, saturating at the ceiling
							if (wd_grace < wd_cfg.busy_grace_max_ms) begin
								if (wd_cfg.probe_period_ms >= wd_cfg.busy_grace_max_ms - wd_grace)
									wd_grace = wd_cfg.busy_grace_max_ms;
								else
									wd_grace = wd_grace + wd_cfg.probe_period_ms;
							end
						end
					end
					since = it.now - wd_alive_at;
					r.dead_for_ms = (since > wd_grace) ? since - wd_grace : '0;
					in_standby = it.now - wd_standby_at;
					if (r.dead_for_ms >= wd_cfg.dead_after_ms) begin
						if (!wd_stage) begin
							wd_stage = 1'b1;
							r.reconnect_request = it.station;
						end else if (r.dead_for_ms >= wd_cfg.reboot_after_ms) begin
							if (it.now >= wd_cfg.min_uptime_ms && wd_standby_at != '0 &&
									in_standby >= wd_cfg.min_standby_ms) begin
								r.reboot_request = 1'b1;
							end else if (!wd_held) begin
								wd_held = 1'b1;
								r.reboot_deferred = 1'b1;
							end
						end
					end
				end
			end
			default: ;
		endcase
		r.escalation_stage = wd_stage;
		return r;
	endfunction

	// Compare one result transfer with the oldest expectation
	task automatic check_result(input lew_pkg::res_t got);
		lew_pkg::res_t want;
		if (verdict_q.size() == 0) begin
			report($sformatf("result %0d arrived with nothing expected", results_seen));
		end else begin
			want = verdict_q.pop_front();
			if (got.probe_taken !== want.probe_taken)
				report($sformatf("result %0d probe_taken %b, want %b", results_seen,
					got.probe_taken, want.probe_taken));
			if (got.reconnect_request !== want.reconnect_request)
				report($sformatf("result %0d reconnect_request %b, want %b", results_seen,
					got.reconnect_request, want.reconnect_request));
			if (got.reboot_request !== want.reboot_request)
				report($sformatf("result %0d reboot_request %b, want %b", results_seen,
					got.reboot_request, want.reboot_request));
			if (got.reboot_deferred !== want.reboot_deferred)
				report($sformatf("result %0d reboot_deferred %b, want %b", results_seen,
					got.reboot_deferred, want.reboot_deferred));
			if (got.escalation_stage !== want.escalation_stage)
				report($sformatf("result %0d escalation_stage %b, want %b", results_seen,
					got.escalation_stage, want.escalation_stage));
			if (got.dead_for_ms !== want.dead_for_ms)
				report($sformatf("result %0d dead_for_ms %0d, want %0d", results_seen,
					got.dead_for_ms, want.dead_for_ms));
		end
		results_seen++;
	endtask

	// Result side: random stalls, plus a long hold-off when asked
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				check_result('{probe_taken, reconnect_request, reboot_request,
					reboot_deferred, escalation_stage, dead_for_ms});
				rx_wait = no_idle ? 0 : $urandom_range(STALL_MAX);
			end
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				rx_hold = HOLD_CYCLES;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				out_ready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Offer one item after a random gap; predict on the transfer
	task automatic push_item(input item_t it, input logic lit, input lew_pkg::res_t want);
		int            gap;
		lew_pkg::res_t p;
		gap = no_idle ? 0 : $urandom_range(STALL_MAX);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= it.func;
		now_ms <= it.now;
		link_up <= it.link_up;
		station_mode <= it.station;
		machine_standby <= it.standby;
		probe_outcome <= it.outcome;
		do @(posedge clk); while (!in_ready);
		p = watchdog_step(it);
		verdict_q.push_back(lit ? want : p);
	endtask

	// Drop valid and wait for the block to drain
	task automatic drain();
		in_valid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// APB write, then read back
	task automatic cfg_write(input logic [lew_pkg::REG_IDX_W-1:0] idx, input logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== v)
			report($sformatf("register %0d reads %h, want %h", idx, prdata, v));
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			lew_pkg::REG_PROBE_PERIOD: wd_cfg.probe_period_ms = v;
			lew_pkg::REG_DEAD_AFTER:   wd_cfg.dead_after_ms = v;
			lew_pkg::REG_REBOOT_AFTER: wd_cfg.reboot_after_ms = v;
			lew_pkg::REG_GRACE_MAX:    wd_cfg.busy_grace_max_ms = v;
			lew_pkg::REG_MIN_UPTIME:   wd_cfg.min_uptime_ms = v;
			lew_pkg::REG_MIN_STANDBY:  wd_cfg.min_standby_ms = v;
			default: ;
		endcase
	endtask

	task automatic set_config(input lew_pkg::cfg_t c);
		cfg_write(lew_pkg::REG_PROBE_PERIOD, c.probe_period_ms);
		cfg_write(lew_pkg::REG_DEAD_AFTER, c.dead_after_ms);
		cfg_write(lew_pkg::REG_REBOOT_AFTER, c.reboot_after_ms);
		cfg_write(lew_pkg::REG_GRACE_MAX, c.busy_grace_max_ms);
		cfg_write(lew_pkg::REG_MIN_UPTIME, c.min_uptime_ms);
		cfg_write(lew_pkg::REG_MIN_STANDBY, c.min_standby_ms);
	endtask

	task automatic add_row(input logic [1:0] f, input logic [31:0] t, input logic lu,
			input logic sm, input logic sb, input logic [1:0] oc, input logic lit);
		row_t r;
		r.it = '{f, t, lu, sm, sb, oc};
		r.lit = lit;
		r.want = '0;
		stim_rows.push_back(r);
	endtask

	// Random traffic: mostly armed ticks with a moving clock, some events and noise
	task automatic run_traffic(input int n, input logic [31:0] step_max, input logic [31:0] t0);
		item_t it;
		int    r;
		logic  sby;
		sby = 1'b0;
		clock_ms = t0;
		it = '{lew_pkg::FUNC_CONNECT, t0, 1'b1, 1'b1, 1'b0, lew_pkg::PROBE_ALIVE};
		push_item(it, 1'b0, '0);
		for (int i = 0; i < n; i++) begin
			if (i % 50 == 0)
				no_idle <= ($urandom_range(3) == 0);
			// long receiver hold-off while items keep coming back to back
			if (i == 110) begin
				hold_asks <= hold_asks + 1;
				no_idle <= 1'b1;
			end
			r = $urandom_range(99);
			if (r < 4)
				it.func = lew_pkg::FUNC_CONNECT;
			else if (r < 7)
				it.func = lew_pkg::FUNC_DISCONNECT;
			else if (r < 9)
				it.func = FUNC_UNUSED;
			else
				it.func = lew_pkg::FUNC_TICK;
			r = $urandom_range(99);
			if (r < 2)
				clock_ms = $urandom;
			else if (r < 3)
				clock_ms = '0;
			else
				clock_ms = clock_ms + $urandom_range(step_max);
			it.now = clock_ms;
			if ($urandom_range(9) == 0)
				sby = ~sby;
			it.standby = sby;
			it.link_up = ($urandom_range(19) != 0);
			it.station = 1'($urandom_range(1));
			r = $urandom_range(99);
			if (r < 10)
				it.outcome = lew_pkg::PROBE_ALIVE;
			else if (r < 35)
				it.outcome = lew_pkg::PROBE_BUSY;
			else if (r < 90)
				it.outcome = PROBE_DEAD;
			else
				it.outcome = PROBE_UNUSED;
			push_item(it, 1'b0, '0);
		end
		drain();
	endtask

	// Run limit
	initial begin
		#5000000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows under the reset register values
		add_row(lew_pkg::FUNC_TICK, 32'd0, 1'b0, 1'b0, 1'b1, lew_pkg::PROBE_ALIVE, 1'b1);
		add_row(FUNC_UNUSED, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, PROBE_UNUSED, 1'b1);
		add_row(lew_pkg::FUNC_DISCONNECT, 32'd123, 1'b1, 1'b1, 1'b0, lew_pkg::PROBE_ALIVE, 1'b1);
		add_row(lew_pkg::FUNC_CONNECT, 32'd1000, 1'b1, 1'b1, 1'b0, lew_pkg::PROBE_ALIVE, 1'b1);
		add_row(lew_pkg::FUNC_TICK, 32'd3000, 1'b1, 1'b1, 1'b0, lew_pkg::PROBE_ALIVE, 1'b0);
		add_row(lew_pkg::FUNC_TICK, 32'd6000, 1'b1, 1'b1, 1'b0, lew_pkg::PROBE_BUSY, 1'b0);
		add_row(lew_pkg::FUNC_TICK, 32'd11000, 1'b1, 1'b1, 1'b0, lew_pkg::PROBE_BUSY, 1'b0);
		add_row(lew_pkg::FUNC_TICK, 32'd70000, 1'b1, 1'b1, 1'b0, PROBE_DEAD, 1'b0);
		add_row(lew_pkg::FUNC_TICK, 32'd75000, 1'b1, 1'b1, 1'b0, PROBE_DEAD, 1'b0);
		add_row(lew_pkg::FUNC_TICK, 32'd400000, 1'b1, 1'b1, 1'b0, PROBE_UNUSED, 1'b0);
		add_row(lew_pkg::FUNC_TICK, 32'd500000, 1'b1, 1'b1, 1'b1, PROBE_DEAD, 1'b0);
		add_row(lew_pkg::FUNC_TICK, 32'd1000000, 1'b1, 1'b1, 1'b1, PROBE_DEAD, 1'b0);
		add_row(lew_pkg::FUNC_TICK, 32'd1005000, 1'b1, 1'b1, 1'b1, lew_pkg::PROBE_ALIVE, 1'b0);
		add_row(lew_pkg::FUNC_TICK, 32'd1006000, 1'b0, 1'b1, 1'b0, PROBE_DEAD, 1'b1);
		add_row(lew_pkg::FUNC_CONNECT, 32'd2000000, 1'b1, 1'b0, 1'b0, PROBE_DEAD, 1'b0);
		add_row(lew_pkg::FUNC_TICK, 32'd2070000, 1'b1, 1'b0, 1'b0, PROBE_DEAD, 1'b0);
		add_row(lew_pkg::FUNC_DISCONNECT, 32'd2070001, 1'b1, 1'b0, 1'b0, PROBE_DEAD, 1'b0);
		add_row(lew_pkg::FUNC_TICK, 32'd2080000, 1'b1, 1'b1, 1'b0, PROBE_DEAD, 1'b1);
		// busy grace across the timestamp wrap
		add_row(lew_pkg::FUNC_CONNECT, 32'hFFFF_F000, 1'b1, 1'b1, 1'b0, lew_pkg::PROBE_ALIVE,
			1'b0);
		for (int k = 1; k <= 4; k++)
			add_row(lew_pkg::FUNC_TICK, 32'hFFFF_F000 + k * 5000, 1'b1, 1'b1, 1'b0,
				lew_pkg::PROBE_BUSY, 1'b0);
		add_row(lew_pkg::FUNC_TICK, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, PROBE_DEAD, 1'b0);
		foreach (stim_rows[i])
			push_item(stim_rows[i].it, stim_rows[i].lit, stim_rows[i].want);
		drain();

		// short thresholds so every escalation path is reached often
		set_config('{32'd7, 32'd60, 32'd150, 32'd30, 32'd400, 32'd100});
		run_traffic(PHASE_ITEMS, 32'd20, 32'hFFFF_FE00);

		// low register values: one for the period and thresholds, zero for the rest
		set_config('{32'd1, 32'd1, 32'd1, 32'd0, 32'd0, 32'd0});
		run_traffic(PHASE_ITEMS, 32'd3, 32'd0);

		// highest register values
		set_config('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF});
		run_traffic(PHASE_ITEMS, 32'hFFFF_FFFF, $urandom);

		// random moderate values
		set_config('{$urandom_range(3000, 1), $urandom_range(3000, 1), $urandom_range(3000, 1),
			$urandom_range(3000), $urandom_range(3000), $urandom_range(3000)});
		run_traffic(PHASE_ITEMS, 32'd200, $urandom);

		// back to the reset values with coarse time steps
		set_config(lew_pkg::CFG_RESET);
		run_traffic(PHASE_ITEMS, 32'd30000, 32'd0);

		if (fault_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
